// ----- rtl/core/terz_pkg.sv -----
// Shared types and constants for the triangle rasterizer with depth buffer.
// Used by the controller, the datapath and the top level; no dependencies.
package terz_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd3;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam int EW        = 36;  // edge function / area width, signed
  localparam int NW        = 52;  // depth numerator width
  localparam int QW        = 16;  // depth width
  localparam int CW        = 24;  // color width
  localparam int FW        = 15;  // fragment count width
  localparam int MEM_W     = CW + QW;
  localparam int MUL_SPLIT = 18;  // edge value split for the 18x16 multiplier

  localparam logic [3:0]    HALF_PIX = 4'd8;  // pixel center in 12.4
  localparam logic [FW-1:0] FRAG_MAX = '1;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] vert0_x;
    logic signed [15:0] vert0_y;
    logic [15:0]        vert0_depth;
    logic signed [15:0] vert1_x;
    logic signed [15:0] vert1_y;
    logic [15:0]        vert1_depth;
    logic signed [15:0] vert2_x;
    logic signed [15:0] vert2_y;
    logic [15:0]        vert2_depth;
    logic [23:0]        tri_color;
  } terz_in_t;

  typedef struct packed {
    logic [23:0] pixel_color;
    logic [15:0] pixel_depth;
    logic [14:0] fragments_written;
  } terz_out_t;

  typedef struct packed {
    logic       load;
    logic       clr_write;
    logic       rd_issue;
    logic       rd_capture;
    logic       setup;
    logic       px_init;
    logic       mul;
    logic       div_load;
    logic       div_step;
    logic       ztest;
    logic       advance;
    logic [2:0] step;
  } terz_cmd_t;

  typedef struct packed {
    logic area_ok;
    logic covered;
    logic last_pix;
    logic clr_last;
  } terz_sts_t;

endpackage

// ----- rtl/core/triangle_edge_raster_zbuffer.sv -----
// Triangle rasterizer with depth buffer, one command at a time.
// Clear: writes every entry of the MAX_WIDTH*MAX_HEIGHT store, one store entry written per cycle.
// Read: store read issue, then capture. Draw: area setup, edge setup, then a test of each box pixel;
// a covered pixel adds 6 multiply steps, divide load, 16 divide steps, depth test; empty skips the walk.
// Result is held until taken; next command is accepted after that transfer.
// Sync active-low reset clears control and config; the store is undefined.
module triangle_edge_raster_zbuffer import terz_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  terz_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output terz_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  terz_cmd_t cmd;
  terz_sts_t sts;

  assign cfg_ready = 1'b1;

  terz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  terz_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ----- rtl/core/terz_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module terz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/terz_ctrl.sv -----
// Sequencer for clear, draw and read commands.
// Depends on terz_pkg; drives the datapath through terz_cmd_t.
module terz_ctrl import terz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_mode,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output terz_cmd_t cmd,
  input  terz_sts_t sts
);

  typedef enum logic [3:0] {
    IDLE, CLEAR, RD_ISSUE, RD_CAP, SET_AREA, CHECK, SET_EDGE,
    PX_TEST, MUL, DLOAD, DIV, ZTEST, DONE
  } state_t;

  localparam logic [3:0] STEP_AREA_LAST  = 4'd1;
  localparam logic [3:0] STEP_EDGE_FIRST = 4'd2;
  localparam logic [3:0] STEP_EDGE_LAST  = 4'd7;
  localparam logic [3:0] STEP_MUL_LAST   = 4'd5;
  localparam logic [3:0] STEP_DIV_LAST   = 4'd15;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       in_ready_r, out_valid_r;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.step  = step_r[2:0];
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          step_nxt = '0;
          case (in_mode)
            MODE_CLEAR: state_nxt = CLEAR;
            MODE_DRAW:  state_nxt = SET_AREA;
            MODE_READ:  state_nxt = RD_ISSUE;
            default:    state_nxt = DONE;
          endcase
        end
      end
      CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = DONE;
      end
      RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = RD_CAP;
      end
      RD_CAP: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = DONE;
      end
      SET_AREA: begin
        cmd.setup = 1'b1;
        if (step_r == STEP_AREA_LAST) state_nxt = CHECK;
        else step_nxt = step_r + 4'd1;
      end
      CHECK: begin
        if (sts.area_ok) begin
          cmd.px_init = 1'b1;
          step_nxt    = STEP_EDGE_FIRST;
          state_nxt   = SET_EDGE;
        end else begin
          state_nxt = DONE;
        end
      end
      SET_EDGE: begin
        cmd.setup = 1'b1;
        if (step_r == STEP_EDGE_LAST) state_nxt = PX_TEST;
        else step_nxt = step_r + 4'd1;
      end
      PX_TEST: begin
        if (sts.covered) begin
          step_nxt  = '0;
          state_nxt = MUL;
        end else begin
          cmd.advance = 1'b1;
          if (sts.last_pix) state_nxt = DONE;
        end
      end
      MUL: begin
        cmd.mul = 1'b1;
        if (step_r == STEP_MUL_LAST) state_nxt = DLOAD;
        else step_nxt = step_r + 4'd1;
      end
      DLOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_DIV_LAST) state_nxt = ZTEST;
        else step_nxt = step_r + 4'd1;
      end
      ZTEST: begin
        cmd.ztest   = 1'b1;
        cmd.advance = 1'b1;
        state_nxt   = sts.last_pix ? DONE : PX_TEST;
      end
      DONE: begin
        if (out_ready) state_nxt = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      step_r      <= '0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      in_ready_r  <= (state_nxt == IDLE);
      out_valid_r <= (state_nxt == DONE);
    end
  end

endmodule

// ----- rtl/core/terz_dp.sv -----
// Datapath: config registers, edge setup and walk, depth interpolation,
// depth test and the pixel store. Depends on terz_pkg and terz_ram.
module terz_dp import terz_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  terz_cmd_t             cmd,
  output terz_sts_t             sts,
  input  terz_in_t              in_data,
  output terz_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_WIDTH + 1);
  localparam int SH    = $clog2(MAX_HEIGHT + 1);

  function automatic logic signed [17:0] ext18(input logic signed [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

  function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // configuration
  logic [7:0]  width_r, height_r;
  logic [15:0] far_r;
  logic [23:0] bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 8'd128;
      far_r    <= 16'hFFFF;
      bg_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[7:0];
        CFG_HEIGHT: height_r <= cfg_data[7:0];
        CFG_FAR:    far_r    <= cfg_data[15:0];
        CFG_BG:     bg_r     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] scr_w;
  logic [SH-1:0] scr_h;

  always_comb begin
    if (width_r == 8'd0) scr_w = SW'(1);
    else if (32'(width_r) > MAX_WIDTH) scr_w = SW'(MAX_WIDTH);
    else scr_w = SW'(width_r);
    if (height_r == 8'd0) scr_h = SH'(1);
    else if (32'(height_r) > MAX_HEIGHT) scr_h = SH'(MAX_HEIGHT);
    else scr_h = SH'(height_r);
  end

  // item
  terz_in_t  item_r;
  terz_out_t res_r;

  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic [15:0]        vd [3];

  assign vx[0] = item_r.vert0_x;
  assign vy[0] = item_r.vert0_y;
  assign vd[0] = item_r.vert0_depth;
  assign vx[1] = item_r.vert1_x;
  assign vy[1] = item_r.vert1_y;
  assign vd[1] = item_r.vert1_depth;
  assign vx[2] = item_r.vert2_x;
  assign vy[2] = item_r.vert2_y;
  assign vd[2] = item_r.vert2_depth;

  // bounding box, clamped to the screen
  logic signed [15:0] minx, miny, maxx, maxy;
  logic signed [12:0] flx0, fly0, flx1, fly1, limx, limy;
  logic signed [12:0] bx0, by0, bx1, by1;
  logic               box_ok;

  assign minx = min3(vx[0], vx[1], vx[2]);
  assign miny = min3(vy[0], vy[1], vy[2]);
  assign maxx = max3(vx[0], vx[1], vx[2]);
  assign maxy = max3(vy[0], vy[1], vy[2]);
  assign flx0 = {minx[15], minx[15:4]};
  assign fly0 = {miny[15], miny[15:4]};
  assign flx1 = {maxx[15], maxx[15:4]};
  assign fly1 = {maxy[15], maxy[15:4]};
  assign limx = $signed(13'(scr_w)) - 13'sd1;
  assign limy = $signed(13'(scr_h)) - 13'sd1;
  assign bx0  = flx0[12] ? 13'sd0 : flx0;
  assign by0  = fly0[12] ? 13'sd0 : fly0;
  assign bx1  = (flx1 > limx) ? limx : flx1;
  assign by1  = (fly1 > limy) ? limy : fly1;
  assign box_ok = (bx0 <= bx1) && (by0 <= by1);

  logic signed [17:0] sx0, sy0;
  assign sx0 = $signed({bx0[12], bx0, HALF_PIX});
  assign sy0 = $signed({by0[12], by0, HALF_PIX});

  // setup: one signed 18x18 product per cycle, two per edge function
  logic [1:0]         sk, skm1;
  logic               sfirst;
  logic signed [17:0] ax, ay, bxv, byv, cx, cy, opa, opb;
  logic signed [35:0] prod;
  logic signed [EW-1:0] acc_r, setup_val;
  logic [EW-1:0]        area_r;
  logic signed [EW-1:0] row_r [3];
  logic signed [EW-1:0] cur_r [3];

  assign sk     = cmd.step[2:1];
  assign skm1   = sk - 2'd1;
  assign sfirst = !cmd.step[0];

  always_comb begin
    case (sk)
      2'd0: begin
        ax = ext18(vx[0]); ay = ext18(vy[0]);
        bxv = ext18(vx[1]); byv = ext18(vy[1]);
        cx = ext18(vx[2]); cy = ext18(vy[2]);
      end
      2'd1: begin
        ax = ext18(vx[1]); ay = ext18(vy[1]);
        bxv = ext18(vx[2]); byv = ext18(vy[2]);
        cx = sx0; cy = sy0;
      end
      2'd2: begin
        ax = ext18(vx[2]); ay = ext18(vy[2]);
        bxv = ext18(vx[0]); byv = ext18(vy[0]);
        cx = sx0; cy = sy0;
      end
      default: begin
        ax = ext18(vx[0]); ay = ext18(vy[0]);
        bxv = ext18(vx[1]); byv = ext18(vy[1]);
        cx = sx0; cy = sy0;
      end
    endcase
    opa = sfirst ? (cx - ax) : (cy - ay);
    opb = sfirst ? (byv - ay) : (bxv - ax);
  end

  assign prod      = opa * opb;
  assign setup_val = acc_r - prod;

  // per-pixel increments of each edge function
  logic signed [EW-1:0] stepx [3];
  logic signed [EW-1:0] stepy [3];

  for (genvar i = 0; i < 3; i++) begin : g_step
    localparam int IA = (i + 1) % 3;
    localparam int IB = (i + 2) % 3;
    logic signed [17:0] ddy, ddx;
    assign ddy      = ext18(vy[IB]) - ext18(vy[IA]);
    assign ddx      = ext18(vx[IA]) - ext18(vx[IB]);
    assign stepx[i] = {{(EW-22){ddy[17]}}, ddy, 4'b0000};
    assign stepy[i] = {{(EW-22){ddx[17]}}, ddx, 4'b0000};
  end

  // walk
  logic [XW-1:0] px_r;
  logic [YW-1:0] py_r;
  logic [AW-1:0] pix_addr;
  logic          row_end;

  assign row_end  = (px_r == bx1[XW-1:0]);
  assign pix_addr = AW'(32'(py_r) * 32'(MAX_WIDTH) + 32'(px_r));

  // depth numerator: 18x16 partial products, one per cycle
  logic [1:0]        mi;
  logic [EW-1:0]     wv;
  logic [17:0]       wpart;
  logic [33:0]       pp;
  logic [NW-1:0]     pp_sh, num_r;
  logic [NW-1:0]     rem_r, dvs_r;
  logic [QW-1:0]     q_r;

  assign mi    = cmd.step[2:1];
  assign wv    = cur_r[mi];
  assign wpart = cmd.step[0] ? wv[EW-1:MUL_SPLIT] : wv[MUL_SPLIT-1:0];
  assign pp    = 34'(wpart) * 34'(vd[mi]);
  assign pp_sh = cmd.step[0] ? (NW'(pp) << MUL_SPLIT) : NW'(pp);

  // pixel store {color, depth}
  logic [AW-1:0]    clr_cnt_r;
  logic             ram_we, zless;
  logic [AW-1:0]    ram_waddr, ram_raddr, rd_addr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;
  logic signed [15:0] rx, ry;
  logic             rd_inb;

  assign rx     = item_r.vert0_x;
  assign ry     = item_r.vert0_y;
  assign rd_inb = !rx[15] && !ry[15] && (32'(rx[14:0]) < 32'(scr_w))
                  && (32'(ry[14:0]) < 32'(scr_h));
  assign rd_addr = AW'(32'(ry[14:0]) * 32'(MAX_WIDTH) + 32'(rx[14:0]));

  assign zless     = (q_r < ram_rdata[QW-1:0]);
  assign ram_we    = cmd.clr_write || (cmd.ztest && zless);
  assign ram_waddr = cmd.clr_write ? clr_cnt_r : pix_addr;
  assign ram_wdata = cmd.clr_write ? {bg_r, far_r} : {item_r.tri_color, q_r};
  assign ram_raddr = cmd.rd_issue ? rd_addr : pix_addr;

  terz_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r    <= in_data;
      res_r     <= '0;
      clr_cnt_r <= '0;
    end

    if (cmd.clr_write) clr_cnt_r <= clr_cnt_r + AW'(1);

    if (cmd.rd_capture && rd_inb) begin
      res_r.pixel_color <= ram_rdata[MEM_W-1:QW];
      res_r.pixel_depth <= ram_rdata[QW-1:0];
    end

    if (cmd.setup) begin
      if (sfirst) begin
        acc_r <= prod;
      end else if (sk == 2'd0) begin
        area_r <= setup_val;
      end else begin
        row_r[skm1] <= setup_val;
        cur_r[skm1] <= setup_val;
      end
    end

    if (cmd.px_init) begin
      px_r <= bx0[XW-1:0];
      py_r <= by0[YW-1:0];
    end

    if (cmd.advance) begin
      if (!row_end) begin
        px_r <= px_r + XW'(1);
        for (int i = 0; i < 3; i++) cur_r[i] <= cur_r[i] + stepx[i];
      end else begin
        px_r <= bx0[XW-1:0];
        py_r <= py_r + YW'(1);
        for (int i = 0; i < 3; i++) begin
          row_r[i] <= row_r[i] + stepy[i];
          cur_r[i] <= row_r[i] + stepy[i];
        end
      end
    end

    if (cmd.mul) num_r <= ((cmd.step == 3'd0) ? '0 : num_r) + pp_sh;

    // rounding: add half the area before the restoring divide
    if (cmd.div_load) begin
      rem_r <= num_r + NW'(area_r[EW-1:1]);
      dvs_r <= NW'(area_r) << (QW - 1);
      q_r   <= '0;
    end

    if (cmd.div_step) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rem_r - dvs_r;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end

    if (cmd.ztest && zless && (res_r.fragments_written != FRAG_MAX)) begin
      res_r.fragments_written <= res_r.fragments_written + FW'(1);
    end
  end

  assign sts.area_ok  = !area_r[EW-1] && (area_r != '0) && box_ok;
  assign sts.covered  = !cur_r[0][EW-1] && !cur_r[1][EW-1] && !cur_r[2][EW-1];
  assign sts.last_pix = row_end && (py_r == by1[YW-1:0]);
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  assign out_data = res_r;

endmodule
